[sv/tac_pkg.sv]
package tac_pkg;

  // Beat kinds carried on the operation field
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  // Keypad codes with a meaning of their own; every other code is a digit
  localparam logic [3:0] KEY_MINUS = 4'd12;
  localparam logic [3:0] KEY_PLUS  = 4'd13;
  localparam logic [3:0] KEY_ARM   = 4'd14;
  localparam logic [3:0] KEY_CLEAR = 4'd15;

  // Digit entry positions
  localparam logic [7:0] POS_SEC_UNITS = 8'd1;
  localparam logic [7:0] POS_SEC_TENS  = 8'd2;
  localparam logic [7:0] POS_MIN_UNITS = 8'd3;
  localparam logic [7:0] POS_MIN_TENS  = 8'd4;
  localparam logic [7:0] POS_HR_UNITS  = 8'd5;
  localparam logic [7:0] POS_HR_TENS   = 8'd6;

  // Limits
  localparam logic [5:0] MAX_SEC_MIN = 6'd59;
  localparam logic [4:0] MAX_HOUR    = 5'd23;
  localparam logic [1:0] RING_LIMIT  = 2'd2;

  // Time of day after reset
  localparam logic [4:0] RST_HOUR = 5'd22;
  localparam logic [5:0] RST_MIN  = 6'd40;
  localparam logic [5:0] RST_SEC  = 6'd52;

endpackage

[sv/time_of_day_alarm_clock.sv]
// An accepted input beat passes the input register, then the state/result register, to its result beat.
// Throughput: one beat per cycle, with no bubbles while out_stall stays low.
// The state registers double as the result register; in_stall only rises when
// both the input register and a result are held up by out_stall.
// Reset (rst, synchronous, active high): time 22:40:52, alarm 00:00:00,
// disarmed, silent, entry position 1, both pipeline stages empty.
module time_of_day_alarm_clock (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [3:0] key_code,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] hours_now,
  output logic [5:0] minutes_now,
  output logic [5:0] seconds_now,
  output logic [4:0] alarm_hours,
  output logic [5:0] alarm_minutes,
  output logic [5:0] alarm_seconds,
  output logic       armed,
  output logic       ringing,
  output logic [7:0] entry_position
);
  import tac_pkg::*;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       s1_valid;
  op_t        s1_op;
  logic [3:0] s1_key;

  logic out_free;   // result register can take a new beat this cycle
  logic advance;    // input register moves into the state/result register
  logic in_take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op  <= op_t'(operation);
      s1_key <= key_code;
    end
  end

  // ---------------------------------------------------------------------
  // Clock / alarm state. These registers are also the result register:
  // they only change when a beat lands, so they hold while a stalled result beat waits.
  // ---------------------------------------------------------------------
  logic [4:0] hour_count,       hour_count_next;
  logic [5:0] minute_count,     minute_count_next;
  logic [5:0] second_count,     second_count_next;
  logic [4:0] alarm_hour_reg,   alarm_hour_reg_next;
  logic [5:0] alarm_minute_reg, alarm_minute_reg_next;
  logic [5:0] alarm_second_reg, alarm_second_reg_next;
  logic       armed_flag,       armed_flag_next;
  logic       ringing_flag,     ringing_flag_next;
  logic [1:0] ring_ticks,       ring_ticks_next;
  logic [7:0] digit_position,   digit_position_next;

  // digit arithmetic: tens value up to 110, sum up to 169
  logic [6:0] digit_tens;
  logic [7:0] sec_sum, min_sum, hr_sum;
  logic       is_digit;
  logic       alarm_match;

  assign digit_tens = {3'd0, s1_key} * 7'd10;
  assign sec_sum    = {2'd0, alarm_second_reg} + {1'b0, digit_tens};
  assign min_sum    = {2'd0, alarm_minute_reg} + {1'b0, digit_tens};
  assign hr_sum     = {3'd0, alarm_hour_reg}   + {1'b0, digit_tens};
  assign is_digit   = (s1_key != KEY_MINUS) && (s1_key != KEY_PLUS)
                   && (s1_key != KEY_ARM)   && (s1_key != KEY_CLEAR);

  always_comb begin
    hour_count_next       = hour_count;
    minute_count_next     = minute_count;
    second_count_next     = second_count;
    alarm_hour_reg_next   = alarm_hour_reg;
    alarm_minute_reg_next = alarm_minute_reg;
    alarm_second_reg_next = alarm_second_reg;
    armed_flag_next       = armed_flag;
    ringing_flag_next     = ringing_flag;
    ring_ticks_next       = ring_ticks;
    digit_position_next   = digit_position;

    unique case (s1_op)
      OP_TICK: begin
        // ring counter saturates at 3, counting even when silent
        if (ring_ticks != 2'd3) begin
          ring_ticks_next = ring_ticks + 2'd1;
        end
        if (second_count >= MAX_SEC_MIN) begin
          second_count_next = '0;
          if (minute_count >= MAX_SEC_MIN) begin
            minute_count_next = '0;
            if (hour_count >= MAX_HOUR) begin
              hour_count_next = '0;
            end else begin
              hour_count_next = hour_count + 5'd1;
            end
          end else begin
            minute_count_next = minute_count + 6'd1;
          end
        end else begin
          second_count_next = second_count + 6'd1;
        end
      end
      OP_KEY: begin
        if (s1_key == KEY_MINUS) begin
          digit_position_next = digit_position - 8'd1;
        end else if (s1_key == KEY_PLUS) begin
          digit_position_next = digit_position + 8'd1;
        end else if (s1_key == KEY_ARM) begin
          armed_flag_next = 1'b1;
        end else if (is_digit) begin
          // position steps on even outside 1..6; the digit is dropped there
          digit_position_next = digit_position + 8'd1;
          if (digit_position == POS_SEC_UNITS) begin
            alarm_second_reg_next = {2'd0, s1_key};
          end else if (digit_position == POS_SEC_TENS) begin
            alarm_second_reg_next = (sec_sum > {2'd0, MAX_SEC_MIN}) ? MAX_SEC_MIN
                                                                    : sec_sum[5:0];
          end else if (digit_position == POS_MIN_UNITS) begin
            alarm_minute_reg_next = {2'd0, s1_key};
          end else if (digit_position == POS_MIN_TENS) begin
            alarm_minute_reg_next = (min_sum > {2'd0, MAX_SEC_MIN}) ? MAX_SEC_MIN
                                                                    : min_sum[5:0];
          end else if (digit_position == POS_HR_UNITS) begin
            alarm_hour_reg_next = {1'b0, s1_key};
          end else if (digit_position == POS_HR_TENS) begin
            // out-of-range hour falls back to midnight; entry restarts
            alarm_hour_reg_next = (hr_sum > {3'd0, MAX_HOUR}) ? 5'd0 : hr_sum[4:0];
            digit_position_next = POS_SEC_UNITS;
          end
        end
        // KEY_CLEAR: no effect
      end
      default: ;
    endcase

    // alarm compare on the updated time; while armed, a match restarts the ring count
    alarm_match = (alarm_hour_reg_next   == hour_count_next)
               && (alarm_minute_reg_next == minute_count_next)
               && (alarm_second_reg_next == second_count_next);
    if (armed_flag_next) begin
      if (alarm_match) begin
        ringing_flag_next = 1'b1;
        ring_ticks_next   = '0;
      end
      if (ringing_flag_next && (ring_ticks_next > RING_LIMIT)) begin
        ringing_flag_next = 1'b0;
        armed_flag_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count       <= RST_HOUR;
      minute_count     <= RST_MIN;
      second_count     <= RST_SEC;
      alarm_hour_reg   <= '0;
      alarm_minute_reg <= '0;
      alarm_second_reg <= '0;
      armed_flag       <= 1'b0;
      ringing_flag     <= 1'b0;
      ring_ticks       <= '0;
      digit_position   <= POS_SEC_UNITS;
    end else if (advance) begin
      hour_count       <= hour_count_next;
      minute_count     <= minute_count_next;
      second_count     <= second_count_next;
      alarm_hour_reg   <= alarm_hour_reg_next;
      alarm_minute_reg <= alarm_minute_reg_next;
      alarm_second_reg <= alarm_second_reg_next;
      armed_flag       <= armed_flag_next;
      ringing_flag     <= ringing_flag_next;
      ring_ticks       <= ring_ticks_next;
      digit_position   <= digit_position_next;
    end
  end

  // result beat valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  assign hours_now      = hour_count;
  assign minutes_now    = minute_count;
  assign seconds_now    = second_count;
  assign alarm_hours    = alarm_hour_reg;
  assign alarm_minutes  = alarm_minute_reg;
  assign alarm_seconds  = alarm_second_reg;
  assign armed          = armed_flag;
  assign ringing        = ringing_flag;
  assign entry_position = digit_position;

endmodule

[sv/tac_checker.sv]
module tac_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] hours_now,
  input logic [5:0] minutes_now,
  input logic [5:0] seconds_now,
  input logic [4:0] alarm_hours,
  input logic [5:0] alarm_minutes,
  input logic [5:0] alarm_seconds,
  input logic       armed,
  input logic       ringing
);
  import tac_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seconds_now)
      && $stable(alarm_seconds) && $stable(ringing))
    else $error("result beat changed under stall");

  // buzzer only sounds with the alarm set
  a_ring_armed: assert property (@(posedge clk) disable iff (rst)
    ringing |-> armed)
    else $error("ringing while disarmed");

  // time and alarm stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seconds_now <= MAX_SEC_MIN) && (minutes_now <= MAX_SEC_MIN)
      && (hours_now <= MAX_HOUR) && (alarm_seconds <= MAX_SEC_MIN)
      && (alarm_minutes <= MAX_SEC_MIN) && (alarm_hours <= MAX_HOUR))
    else $error("time field out of range");

  // state moves only when a new result beat is shown
  a_change_with_beat: assert property (@(posedge clk) disable iff (rst)
    !$stable(seconds_now) || !$stable(armed) |-> out_valid)
    else $error("state changed without a result beat");

endmodule

bind time_of_day_alarm_clock tac_checker u_tac_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .hours_now     (hours_now),
  .minutes_now   (minutes_now),
  .seconds_now   (seconds_now),
  .alarm_hours   (alarm_hours),
  .alarm_minutes (alarm_minutes),
  .alarm_seconds (alarm_seconds),
  .armed         (armed),
  .ringing       (ringing)
);
